// File: rtl/fgp_pkg.sv
// fgp_pkg: shared constants, rule tables and sequencer codes for the
// fuzzy gain-scheduled PID unit. No dependencies.
`default_nettype none

package fgp_pkg;

   localparam int unsigned GAIN_W  = 26;
   localparam int unsigned NORM_W  = 31;
   localparam int unsigned DATA_W  = 32;
   localparam int unsigned STEP_W  = 17;
   localparam int unsigned MOP_W   = 33;
   localparam int unsigned PROD_W  = 2 * MOP_W;
   localparam int unsigned SCALE_W = 27;
   localparam int unsigned DIV_W   = 49;
   localparam int unsigned CNT_W   = 6;
   localparam int unsigned FUZ_W   = 19;
   localparam int unsigned ACC_W   = 37;

   localparam logic [SCALE_W-1:0] KP_ADJUST_SCALE_DEF = SCALE_W'(65536);
   localparam logic [SCALE_W-1:0] KI_ADJUST_SCALE_DEF = SCALE_W'(65536);
   localparam logic [SCALE_W-1:0] KD_ADJUST_SCALE_DEF = SCALE_W'(65536);

   localparam int NORM_MAX = 3 * 65536;
   localparam int GAIN_MAX = 65536000;

   // register indexes
   localparam logic [2:0] REG_BASE_P = 3'd0;
   localparam logic [2:0] REG_BASE_I = 3'd1;
   localparam logic [2:0] REG_BASE_D = 3'd2;
   localparam logic [2:0] REG_ENORM  = 3'd3;
   localparam logic [2:0] REG_RNORM  = 3'd4;
   localparam logic [2:0] REG_LOWER  = 3'd5;
   localparam logic [2:0] REG_UPPER  = 3'd6;
   localparam logic [2:0] REG_ALIM   = 3'd7;

   localparam int TAB_P [7][7] = '{
      '{3, 3, 2, 2, 1, 0, 0},
      '{3, 3, 2, 1, 1, 0, -1},
      '{2, 2, 2, 1, 0, -1, -1},
      '{2, 2, 1, 0, -1, -2, -2},
      '{1, 1, 0, -1, -1, -2, -2},
      '{1, 0, -1, -2, -2, -2, -3},
      '{0, 0, -2, -2, -2, -3, -3}};

   localparam int TAB_I [7][7] = '{
      '{-3, -3, -2, -2, -1, 0, 0},
      '{-3, -3, -2, -1, -1, 0, 0},
      '{-2, -2, -1, -1, 0, 1, 1},
      '{-2, -1, -1, 0, 1, 1, 2},
      '{-1, -1, 0, 1, 1, 2, 2},
      '{0, 0, 1, 1, 2, 3, 3},
      '{0, 0, 1, 2, 2, 3, 3}};

   localparam int TAB_D [7][7] = '{
      '{1, -1, -3, -3, -3, -2, 1},
      '{1, -1, -3, -2, -2, -1, 0},
      '{0, -1, -2, -2, -1, -1, 0},
      '{0, -1, -1, -1, -1, -1, 0},
      '{0, 0, 0, 0, 0, 0, 0},
      '{3, -1, 1, 1, 1, 1, 3},
      '{3, 2, 2, 2, 1, 1, 3}};

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_PREP = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_MUL  = 5'b01000,
      ST_FIN  = 5'b10000
   } state_type;

   typedef enum logic [3:0] {
      OP_EN  = 4'd0,
      OP_ECN = 4'd1,
      OP_W00 = 4'd2,
      OP_W01 = 4'd3,
      OP_W10 = 4'd4,
      OP_W11 = 4'd5,
      OP_KP  = 4'd6,
      OP_KI  = 4'd7,
      OP_KD  = 4'd8,
      OP_INC = 4'd9,
      OP_UP  = 4'd10,
      OP_UI  = 4'd11,
      OP_UD  = 4'd12
   } op_type;

   typedef struct packed {
      logic start;
      logic done;
   } div_ctl_type;

   // weight times rule value in -3..3, shift and add only
   function automatic logic signed [ACC_W-1:0] rule_mul(
      input logic signed [ACC_W-1:0] w, input logic signed [2:0] r);
      logic signed [ACC_W-1:0] mag;
      logic [1:0] m;
      m = r[2] ? 2'(-r) : r[1:0];
      case (m)
         2'd0:    mag = '0;
         2'd1:    mag = w;
         2'd2:    mag = w <<< 1;
         2'd3:    mag = w + (w <<< 1);
         default: mag = '0;
      endcase
      return r[2] ? -mag : mag;
   endfunction

endpackage

`default_nettype wire

// File: rtl/fgp_mul.sv
// fgp_mul: shared signed 33x33 multiplier with registered product.
// Depends on fgp_pkg.
`default_nettype none

module fgp_mul (
   input  wire logic                                clock,
   input  wire logic signed [fgp_pkg::MOP_W-1:0]    op_a,
   input  wire logic signed [fgp_pkg::MOP_W-1:0]    op_b,
   output logic signed [fgp_pkg::PROD_W-1:0]        prod
);

   logic signed [fgp_pkg::PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= fgp_pkg::PROD_W'(op_a) * fgp_pkg::PROD_W'(op_b);
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// File: rtl/fgp_div.sv
// fgp_div: restoring divider, one quotient bit per cycle, unsigned.
// Depends on fgp_pkg.
`default_nettype none

module fgp_div (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [fgp_pkg::DIV_W-1:0]        dividend,
   input  wire logic [fgp_pkg::STEP_W-1:0]       divisor,
   output logic                                  done,
   output logic [fgp_pkg::DIV_W-1:0]             quotient
);

   logic                          busy_ff;
   logic                          done_ff;
   logic [fgp_pkg::CNT_W-1:0]     cnt_ff;
   logic [fgp_pkg::STEP_W-1:0]    rem_ff;
   logic [fgp_pkg::DIV_W-1:0]     quo_ff;
   logic [fgp_pkg::STEP_W:0]      trial;
   logic                          fits;

   assign trial = {rem_ff, quo_ff[fgp_pkg::DIV_W-1]};
   assign fits  = trial >= {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= fgp_pkg::CNT_W'(fgp_pkg::DIV_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         rem_ff <= fits ? fgp_pkg::STEP_W'(trial - {1'b0, divisor})
                        : fgp_pkg::STEP_W'(trial);
         quo_ff <= {quo_ff[fgp_pkg::DIV_W-2:0], fits};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// File: rtl/fuzzy_gain_scheduled_pid_unit.sv
// Fuzzy gain-scheduled PID unit, Q16.16 throughout.
// A zero step goes from accept straight to the output state; otherwise the path to rsp_valid is:
// a prep state, 49 divider iterations plus the divider's done strobe for the error rate,
// 13 passes through the shared 33x33 multiplier (issue, then take product), then the output state.
// Ready only while idle: the next request waits until FIN hands its word to the output register.
// Reset (synchronous, active high) clears state, registers to defaults.
`default_nettype none

module fuzzy_gain_scheduled_pid_unit #(
   parameter logic [fgp_pkg::SCALE_W-1:0] KP_ADJUST_SCALE = fgp_pkg::KP_ADJUST_SCALE_DEF,
   parameter logic [fgp_pkg::SCALE_W-1:0] KI_ADJUST_SCALE = fgp_pkg::KI_ADJUST_SCALE_DEF,
   parameter logic [fgp_pkg::SCALE_W-1:0] KD_ADJUST_SCALE = fgp_pkg::KD_ADJUST_SCALE_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic signed [31:0]      req_target_value,
   input  wire logic signed [31:0]      req_measured_value,
   input  wire logic [16:0]             req_step_time,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic signed [31:0]           rsp_drive_value,
   input  wire logic                    csr_we,
   input  wire logic [2:0]              csr_index,
   input  wire logic [31:0]             csr_wdata
);

   localparam int unsigned MW = fgp_pkg::MOP_W;
   localparam int unsigned PW = fgp_pkg::PROD_W;
   localparam int unsigned AW = fgp_pkg::ACC_W;
   localparam int unsigned FW = fgp_pkg::FUZ_W;

   // configuration registers
   logic [25:0]        base_p_ff, base_i_ff, base_d_ff;
   logic [30:0]        enorm_ff, rnorm_ff, alim_ff;
   logic signed [31:0] lower_ff, upper_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_p_ff <= 26'd65536;
         base_i_ff <= '0;
         base_d_ff <= '0;
         enorm_ff  <= 31'd65536;
         rnorm_ff  <= 31'd65536;
         lower_ff  <= 32'sh8000_0000;
         upper_ff  <= 32'sh7fff_ffff;
         alim_ff   <= 31'h7fff_ffff;
      end else if (csr_we) begin
         case (csr_index)
            fgp_pkg::REG_BASE_P: base_p_ff <= csr_wdata[25:0];
            fgp_pkg::REG_BASE_I: base_i_ff <= csr_wdata[25:0];
            fgp_pkg::REG_BASE_D: base_d_ff <= csr_wdata[25:0];
            fgp_pkg::REG_ENORM:  enorm_ff  <= csr_wdata[30:0];
            fgp_pkg::REG_RNORM:  rnorm_ff  <= csr_wdata[30:0];
            fgp_pkg::REG_LOWER:  lower_ff  <= csr_wdata;
            fgp_pkg::REG_UPPER:  upper_ff  <= csr_wdata;
            fgp_pkg::REG_ALIM:   alim_ff   <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // sequencer and working registers
   fgp_pkg::state_type state_ff;
   fgp_pkg::op_type    op_ff;
   logic               phase_ff;      // 0: issue to multiplier, 1: take product
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_drive_ff;

   logic signed [31:0] last_err_ff, integral_ff;
   logic signed [31:0] err_ff, rate_ff, integ_ff, drive_ff;
   logic [16:0]        dt_ff;
   logic               dneg_ff;
   logic signed [FW-1:0] en_ff, ecn_ff;
   logic signed [AW-1:0] accp_ff, acci_ff, accd_ff;
   logic [25:0]        kp_ff, ki_ff, kd_ff;
   logic signed [32:0] inc_ff;
   logic signed [PW-1:0] usum_ff;

   // error at accept: saturated difference
   logic signed [32:0] err_wide;
   logic signed [31:0] err_sat;
   assign err_wide = 33'(req_target_value) - 33'(req_measured_value);
   always_comb begin
      if (err_wide > 33'sh0_7fff_ffff)       err_sat = 32'sh7fff_ffff;
      else if (err_wide < -33'sh0_8000_0000) err_sat = 32'sh8000_0000;
      else                                   err_sat = err_wide[31:0];
   end

   // rate dividend: (err - last) * 2^16, split into sign and magnitude
   logic signed [32:0]           ediff;
   logic signed [fgp_pkg::DIV_W:0] num;
   logic [fgp_pkg::DIV_W-1:0]    num_mag;
   assign ediff   = 33'(err_ff) - 33'(last_err_ff);
   assign num     = (fgp_pkg::DIV_W + 1)'(ediff) <<< 16;
   assign num_mag = num[fgp_pkg::DIV_W] ? fgp_pkg::DIV_W'(-num) : fgp_pkg::DIV_W'(num);

   fgp_pkg::div_ctl_type        div_ctl;
   logic [fgp_pkg::DIV_W-1:0]   quo;

   assign div_ctl.start = (state_ff == fgp_pkg::ST_PREP);

   fgp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_ctl.start),
      .dividend (num_mag),
      .divisor  (dt_ff),
      .done     (div_ctl.done),
      .quotient (quo)
   );

   // quotient truncated toward zero, saturated to 32 bits
   logic signed [31:0] rate_sat;
   always_comb begin
      if (dneg_ff) begin
         if (quo > fgp_pkg::DIV_W'(33'h0_8000_0000)) rate_sat = 32'sh8000_0000;
         else                                        rate_sat = -$signed(quo[31:0]);
      end else begin
         if (quo > fgp_pkg::DIV_W'(33'h0_7fff_ffff)) rate_sat = 32'sh7fff_ffff;
         else                                        rate_sat = $signed(quo[31:0]);
      end
   end

   // fuzzification: two adjacent triangles, weights 1-f and f
   logic [FW:0]  xe, xc;
   logic [2:0]   ie_lo, ie_hi, ic_lo, ic_hi;
   logic [16:0]  mue_lo, mue_hi, muc_lo, muc_hi;
   assign xe     = (FW + 1)'(en_ff) + (FW + 1)'(fgp_pkg::NORM_MAX);
   assign xc     = (FW + 1)'(ecn_ff) + (FW + 1)'(fgp_pkg::NORM_MAX);
   assign ie_lo  = xe[18:16];
   assign ic_lo  = xc[18:16];
   assign ie_hi  = (ie_lo == 3'd6) ? 3'd6 : ie_lo + 3'd1;
   assign ic_hi  = (ic_lo == 3'd6) ? 3'd6 : ic_lo + 3'd1;
   assign mue_hi = {1'b0, xe[15:0]};
   assign muc_hi = {1'b0, xc[15:0]};
   assign mue_lo = 17'h1_0000 - mue_hi;
   assign muc_lo = 17'h1_0000 - muc_hi;

   // multiplier operand select
   logic signed [MW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] prod;
   logic signed [19:0]   offp, offi, offd;
   assign offp = accp_ff[35:16];
   assign offi = acci_ff[35:16];
   assign offd = accd_ff[35:16];

   always_comb begin
      case (op_ff)
         fgp_pkg::OP_EN:  begin mul_a = MW'(err_ff);  mul_b = MW'({1'b0, enorm_ff}); end
         fgp_pkg::OP_ECN: begin mul_a = MW'(rate_ff); mul_b = MW'({1'b0, rnorm_ff}); end
         fgp_pkg::OP_W00: begin mul_a = MW'(mue_lo);  mul_b = MW'(muc_lo); end
         fgp_pkg::OP_W01: begin mul_a = MW'(mue_lo);  mul_b = MW'(muc_hi); end
         fgp_pkg::OP_W10: begin mul_a = MW'(mue_hi);  mul_b = MW'(muc_lo); end
         fgp_pkg::OP_W11: begin mul_a = MW'(mue_hi);  mul_b = MW'(muc_hi); end
         fgp_pkg::OP_KP:  begin mul_a = MW'(offp); mul_b = MW'({1'b0, KP_ADJUST_SCALE}); end
         fgp_pkg::OP_KI:  begin mul_a = MW'(offi); mul_b = MW'({1'b0, KI_ADJUST_SCALE}); end
         fgp_pkg::OP_KD:  begin mul_a = MW'(offd); mul_b = MW'({1'b0, KD_ADJUST_SCALE}); end
         fgp_pkg::OP_INC: begin mul_a = MW'(err_ff);  mul_b = MW'(dt_ff); end
         fgp_pkg::OP_UP:  begin mul_a = MW'(kp_ff);   mul_b = MW'(err_ff); end
         fgp_pkg::OP_UI:  begin mul_a = MW'(ki_ff);   mul_b = MW'(integ_ff); end
         fgp_pkg::OP_UD:  begin mul_a = MW'(kd_ff);   mul_b = MW'(rate_ff); end
         default:         begin mul_a = '0; mul_b = '0; end
      endcase
   end

   fgp_mul u_mul (
      .clock (clock),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .prod  (prod)
   );

   // product post-processing
   logic signed [PW-1:0] prod_sh;
   logic signed [FW-1:0] norm_sat;
   assign prod_sh = prod >>> 16;
   always_comb begin
      if (prod_sh > PW'(fgp_pkg::NORM_MAX))       norm_sat = FW'(fgp_pkg::NORM_MAX);
      else if (prod_sh < -PW'(fgp_pkg::NORM_MAX)) norm_sat = -FW'(fgp_pkg::NORM_MAX);
      else                                        norm_sat = prod_sh[FW-1:0];
   end

   // rule lookup for the current corner
   logic [2:0]         ri, rj;
   logic signed [AW-1:0] wgt;
   assign ri  = (op_ff == fgp_pkg::OP_W10 || op_ff == fgp_pkg::OP_W11) ? ie_hi : ie_lo;
   assign rj  = (op_ff == fgp_pkg::OP_W01 || op_ff == fgp_pkg::OP_W11) ? ic_hi : ic_lo;
   assign wgt = prod[AW-1:0];

   // gain: base + scaled offset, clamped to 0..1000
   logic [25:0]        gbase;
   logic signed [31:0] gsum;
   logic [25:0]        gain_sat;
   always_comb begin
      case (op_ff)
         fgp_pkg::OP_KI: gbase = base_i_ff;
         fgp_pkg::OP_KD: gbase = base_d_ff;
         default:        gbase = base_p_ff;
      endcase
   end
   assign gsum = $signed({6'b0, gbase}) + prod_sh[31:0];
   always_comb begin
      if (gsum < 0)                          gain_sat = '0;
      else if (gsum > 32'(fgp_pkg::GAIN_MAX)) gain_sat = 26'(fgp_pkg::GAIN_MAX);
      else                                   gain_sat = gsum[25:0];
   end

   // integral with symmetric clamp; increment is signed, sign-extend it
   logic signed [33:0] isum, ilim;
   logic signed [31:0] integ_clamp;
   assign isum = 34'(integral_ff) + 34'($signed(prod_sh[32:0]));
   assign ilim = $signed({3'b0, alim_ff});
   always_comb begin
      if (isum > ilim)       integ_clamp = ilim[31:0];
      else if (isum < -ilim) integ_clamp = -ilim[31:0];
      else                   integ_clamp = isum[31:0];
   end

   // final sum, output clamp and anti-windup
   logic signed [PW-1:0] utot, u, lo_w, hi_w;
   logic signed [33:0]   iback;
   logic signed [31:0]   iback_sat, drive_next, integ_next;
   logic                 windup;
   assign utot  = usum_ff + prod;
   assign u     = utot >>> 16;
   assign lo_w  = PW'(lower_ff);
   assign hi_w  = PW'(upper_ff);
   assign windup = (u > hi_w && err_ff > 0) || (u < lo_w && err_ff < 0);
   assign iback = 34'(integ_ff) - 34'(inc_ff);
   always_comb begin
      if (u < lo_w)      drive_next = lower_ff;
      else if (u > hi_w) drive_next = upper_ff;
      else               drive_next = u[31:0];
      if (iback > 34'sh0_7fff_ffff)       iback_sat = 32'sh7fff_ffff;
      else if (iback < -34'sh0_8000_0000) iback_sat = 32'sh8000_0000;
      else                                iback_sat = iback[31:0];
      integ_next = windup ? iback_sat : integ_ff;
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fgp_pkg::ST_IDLE;
         op_ff        <= fgp_pkg::OP_EN;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         last_err_ff  <= '0;
         integral_ff  <= '0;
      end else begin
         // output register: load from FIN, else drop once taken
         if (state_ff == fgp_pkg::ST_FIN && (!rsp_valid_ff || rsp_ready))
            rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_ready)
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            fgp_pkg::ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= (req_step_time == '0) ? fgp_pkg::ST_FIN : fgp_pkg::ST_PREP;
               end
            end
            fgp_pkg::ST_PREP: state_ff <= fgp_pkg::ST_DIV;
            fgp_pkg::ST_DIV: begin
               if (div_ctl.done) begin
                  state_ff <= fgp_pkg::ST_MUL;
                  op_ff    <= fgp_pkg::OP_EN;
                  phase_ff <= 1'b0;
               end
            end
            fgp_pkg::ST_MUL: begin
               phase_ff <= ~phase_ff;
               if (phase_ff) begin
                  if (op_ff == fgp_pkg::OP_UD) begin
                     state_ff    <= fgp_pkg::ST_FIN;
                     op_ff       <= fgp_pkg::OP_EN;
                     last_err_ff <= err_ff;
                     integral_ff <= integ_next;
                  end else begin
                     op_ff <= fgp_pkg::op_type'(op_ff + 4'd1);
                  end
               end
            end
            fgp_pkg::ST_FIN: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  state_ff <= fgp_pkg::ST_IDLE;
               end
            end
            default: state_ff <= fgp_pkg::ST_IDLE;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == fgp_pkg::ST_IDLE && req_valid) begin
         err_ff   <= err_sat;
         dt_ff    <= req_step_time;
         drive_ff <= '0;
      end
      if (state_ff == fgp_pkg::ST_PREP) begin
         dneg_ff <= num[fgp_pkg::DIV_W];
         accp_ff <= '0;
         acci_ff <= '0;
         accd_ff <= '0;
      end
      if (state_ff == fgp_pkg::ST_DIV && div_ctl.done) rate_ff <= rate_sat;
      if (state_ff == fgp_pkg::ST_MUL && phase_ff) begin
         case (op_ff)
            fgp_pkg::OP_EN:  en_ff  <= norm_sat;
            fgp_pkg::OP_ECN: ecn_ff <= norm_sat;
            fgp_pkg::OP_W00, fgp_pkg::OP_W01, fgp_pkg::OP_W10, fgp_pkg::OP_W11: begin
               accp_ff <= accp_ff + fgp_pkg::rule_mul(wgt, 3'(fgp_pkg::TAB_P[ri][rj]));
               acci_ff <= acci_ff + fgp_pkg::rule_mul(wgt, 3'(fgp_pkg::TAB_I[ri][rj]));
               accd_ff <= accd_ff + fgp_pkg::rule_mul(wgt, 3'(fgp_pkg::TAB_D[ri][rj]));
            end
            fgp_pkg::OP_KP:  kp_ff <= gain_sat;
            fgp_pkg::OP_KI:  ki_ff <= gain_sat;
            fgp_pkg::OP_KD:  kd_ff <= gain_sat;
            fgp_pkg::OP_INC: begin
               inc_ff   <= prod_sh[32:0];
               integ_ff <= integ_clamp;
            end
            fgp_pkg::OP_UP:  usum_ff <= prod;
            fgp_pkg::OP_UI:  usum_ff <= utot;
            fgp_pkg::OP_UD:  drive_ff <= drive_next;
            default: ;
         endcase
      end
      if (state_ff == fgp_pkg::ST_FIN && (!rsp_valid_ff || rsp_ready)) begin
         rsp_drive_ff <= drive_ff;
      end
   end

   assign req_ready       = (state_ff == fgp_pkg::ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_value = rsp_drive_ff;

`ifndef SYNTHESIS
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("sequencer state not one-hot");

   a_zero_step: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_step_time == '0 |=> state_ff == fgp_pkg::ST_FIN)
      else $error("zero step did not bypass the datapath");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_ctl.done |-> state_ff == fgp_pkg::ST_DIV)
      else $error("divider finished outside the divide state");

   a_op_range: assert property (@(posedge clock) disable iff (reset)
      op_ff <= fgp_pkg::OP_UD) else $error("multiplier step out of range");
`endif

endmodule

`default_nettype wire
